/* rtl/uvss_pkg.sv */
// Shared types and command codes for the unique value set store.
package uvss_pkg;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned COUNT_BITS = 5;

  typedef struct packed {
    cmd_t                         cmd;
    logic signed [VALUE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                  was_present;
    logic                  inserted;
    logic                  full_drop;
    logic [COUNT_BITS-1:0] count;
  } out_item_t;

  // Per-cell write control from the top level.
  typedef struct packed {
    logic load;   // take the new key
    logic shift;  // take the upper neighbor's entry
  } cell_ctrl_t;

endpackage

/* rtl/uvss_cell.sv */
// One storage cell of the set: holds an entry, compares it, extends the hit chain.
module uvss_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   valid,
  input  logic [VALUE_WIDTH-1:0] key,
  input  logic [VALUE_WIDTH-1:0] nb_value,
  input  uvss_pkg::cell_ctrl_t   ctrl,
  input  logic                   hit_in,
  output logic                   hit_out,
  output logic [VALUE_WIDTH-1:0] value
);

  logic [VALUE_WIDTH-1:0] value_r;
  logic                   match;

  assign match   = valid && (value_r == key);
  // Hit at this cell or any lower one: marks the cells that shift on remove.
  assign hit_out = hit_in | match;
  assign value   = value_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value_r <= key;
    end else if (ctrl.shift) begin
      value_r <= nb_value;
    end
  end

endmodule

/* rtl/unique_value_set_store_core.sv */
// Unique value set store: a row of cells holding distinct values in insertion order.
// The result strobe is registered and comes in the cycle after the item is taken.
// Throughput: one item per cycle; busy stays low, so start may be held high.
// Cycle time is set by the key compare in every cell and the hit chain rippling
// through the row, which decide the one-place shift of a remove.
// Reset (synchronous, rst_n low) empties the set and clears the result strobe.
module unique_value_set_store_core #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  uvss_pkg::in_item_t  in_data,
  output logic                out_valid,
  output uvss_pkg::out_item_t out_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]          count_r;
  logic [CW-1:0]          count_nxt;
  logic                   out_valid_r;
  uvss_pkg::out_item_t    out_data_r;
  uvss_pkg::out_item_t    out_data_nxt;

  logic                   accept;
  logic [VALUE_WIDTH-1:0] key;
  logic [CAPACITY:0]      hit;
  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  uvss_pkg::cell_ctrl_t   ctrl     [CAPACITY];
  logic                   present;
  logic                   full;
  logic                   do_insert;
  logic                   do_drop;
  logic                   is_add;
  logic                   is_remove;
  logic [CW+4:0]          count_ext;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign key     = VALUE_WIDTH'($unsigned(in_data.value));
  assign hit[0]  = 1'b0;
  assign present = hit[CAPACITY];
  assign full    = (count_r == CW'(CAPACITY));

  assign is_add    = (in_data.cmd == uvss_pkg::CMD_ADD);
  assign is_remove = (in_data.cmd == uvss_pkg::CMD_REMOVE);
  assign do_insert = accept && is_add && !present && !full;
  assign do_drop   = accept && is_add && !present && full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] nb;

    if (i == CAPACITY - 1) begin : g_last
      // Top cell falls out of the valid range on a remove; keep its entry.
      assign nb = cell_val[i];
    end else begin : g_mid
      assign nb = cell_val[i+1];
    end

    assign ctrl[i].load  = do_insert && (count_r == CW'(i));
    assign ctrl[i].shift = accept && is_remove && hit[i+1];

    uvss_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk     (clk),
      .valid   (CW'(i) < count_r),
      .key     (key),
      .nb_value(nb),
      .ctrl    (ctrl[i]),
      .hit_in  (hit[i]),
      .hit_out (hit[i+1]),
      .value   (cell_val[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    case (in_data.cmd)
      uvss_pkg::CMD_ADD: begin
        if (do_insert) count_nxt = count_r + CW'(1);
      end
      uvss_pkg::CMD_REMOVE: begin
        if (present) count_nxt = count_r - CW'(1);
      end
      uvss_pkg::CMD_LOOKUP: begin
        count_nxt = count_r;
      end
      uvss_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  assign count_ext = (CW+5)'(count_nxt);

  always_comb begin
    out_data_nxt.was_present = present;
    out_data_nxt.inserted    = do_insert;
    out_data_nxt.full_drop   = do_drop;
    out_data_nxt.count       = count_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload: no reset, qualified by the strobe.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_add_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.inserted && (out_data.was_present || out_data.full_drop)))
    else $error("insert flagged together with presence or drop");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without an accepted item");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.cmd == uvss_pkg::CMD_LOOKUP) |=> $stable(count_r))
    else $error("lookup changed the entry count");

endmodule

/* tb/sv/unique_value_set_store_checker.sv */
// Checker for the unique value set store: predicts each result and compares it.
`timescale 1ns / 100ps

module unique_value_set_store_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  uvss_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  uvss_pkg::out_item_t out_data,
  output int unsigned         fail_count,
  output int unsigned         pending
);

  logic [uvss_pkg::VALUE_BITS-1:0] set_entries [CAPACITY];
  int unsigned                     set_size;
  uvss_pkg::out_item_t             expected_outcomes[$];

  initial begin
    fail_count = 0;
    set_size   = 0;
  end

  assign pending = expected_outcomes.size();

  task automatic report_mismatch(input string what, input int unsigned exp_val,
                                 input int unsigned got_val);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, exp_val, got_val);
    fail_count++;
  endtask

  // Apply one command to the shadow set and return what the block should answer.
  function automatic uvss_pkg::out_item_t apply_set_cmd(input uvss_pkg::in_item_t item);
    uvss_pkg::out_item_t res;
    int                  hit_pos;
    hit_pos = -1;
    for (int i = 0; i < set_size; i++) begin
      if (hit_pos < 0 && set_entries[i] == item.value) hit_pos = i;
    end
    res             = '0;
    res.was_present = (hit_pos >= 0);
    case (item.cmd)
      uvss_pkg::CMD_ADD: begin
        if (hit_pos < 0) begin
          if (set_size < CAPACITY) begin
            set_entries[set_size] = item.value;
            set_size++;
            res.inserted = 1'b1;
          end else begin
            res.full_drop = 1'b1;
          end
        end
      end
      uvss_pkg::CMD_REMOVE: begin
        if (hit_pos >= 0) begin
          // close the hole: later entries move down one place
          for (int j = hit_pos; j + 1 < set_size; j++) set_entries[j] = set_entries[j + 1];
          set_size--;
        end
      end
      uvss_pkg::CMD_LOOKUP: ;
      uvss_pkg::CMD_CLEAR: set_size = 0;
      default: ;
    endcase
    res.count = set_size[uvss_pkg::COUNT_BITS-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      set_size = 0;
      expected_outcomes.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result with no item outstanding", $time);
          fail_count++;
        end else begin
          uvss_pkg::out_item_t exp_res;
          exp_res = expected_outcomes.pop_front();
          if (out_data.was_present !== exp_res.was_present)
            report_mismatch("was_present", exp_res.was_present, out_data.was_present);
          if (out_data.inserted !== exp_res.inserted)
            report_mismatch("inserted", exp_res.inserted, out_data.inserted);
          if (out_data.full_drop !== exp_res.full_drop)
            report_mismatch("full_drop", exp_res.full_drop, out_data.full_drop);
          if (out_data.count !== exp_res.count)
            report_mismatch("count", exp_res.count, out_data.count);
        end
      end else if (out_valid !== 1'b0) begin
        $display("%0t: out_valid is unknown", $time);
        fail_count++;
      end
      if (start === 1'b1 && busy === 1'b0)
        expected_outcomes.push_back(apply_set_cmd(in_data));
    end
  end

endmodule

/* tb/sv/unique_value_set_store_core_tb.sv */
// Testbench top for the unique value set store: stimulus, timeout and verdict.
`timescale 1ns / 100ps

module unique_value_set_store_core_tb;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned POOL_SIZE    = 24;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  uvss_pkg::in_item_t  in_data;
  logic                out_valid;
  uvss_pkg::out_item_t out_data;
  int unsigned         fail_count;
  int unsigned         pending;
  int unsigned         cycle_count;

  logic [uvss_pkg::VALUE_BITS-1:0] value_pool [POOL_SIZE];
  int unsigned                     pool_span;
  bit                              no_gaps;

  unique_value_set_store_core #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(uvss_pkg::VALUE_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  unique_value_set_store_checker #(
    .CAPACITY(CAPACITY)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Hold the item on the inputs until the block takes it.
  task automatic send_item(input uvss_pkg::cmd_t cmd,
                           input logic [uvss_pkg::VALUE_BITS-1:0] value);
    uvss_pkg::in_item_t item;
    item.cmd   = cmd;
    item.value = value;
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Mostly short gaps, a few long ones; none inside a burst stretch.
  task automatic idle_gap();
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) len = 0;
    else if (roll < 92) len = $urandom_range(1, 3);
    else len = $urandom_range(5, 40);
    if (len != 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [uvss_pkg::VALUE_BITS-1:0] pick_value();
    if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, pool_span - 1)];
    return $urandom();
  endfunction

  function automatic uvss_pkg::cmd_t pick_cmd();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 48) return uvss_pkg::CMD_ADD;
    if (roll < 75) return uvss_pkg::CMD_REMOVE;
    if (roll < 97) return uvss_pkg::CMD_LOOKUP;
    return uvss_pkg::CMD_CLEAR;
  endfunction

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    no_gaps = 1'b0;
    pool_span = POOL_SIZE;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty set, extremes, duplicates, shift on remove, full set, clear
    send_item(uvss_pkg::CMD_REMOVE, 32'h0000_0005);
    send_item(uvss_pkg::CMD_ADD, 32'h8000_0000);
    send_item(uvss_pkg::CMD_ADD, 32'h7FFF_FFFF);
    send_item(uvss_pkg::CMD_ADD, 32'h0000_0000);
    send_item(uvss_pkg::CMD_ADD, 32'hFFFF_FFFF);
    send_item(uvss_pkg::CMD_ADD, 32'h7FFF_FFFF);
    send_item(uvss_pkg::CMD_LOOKUP, 32'h8000_0000);
    send_item(uvss_pkg::CMD_LOOKUP, 32'h0000_0001);
    send_item(uvss_pkg::CMD_REMOVE, 32'h7FFF_FFFF);
    send_item(uvss_pkg::CMD_REMOVE, 32'h1234_5678);
    for (int i = 0; i < 13; i++) send_item(uvss_pkg::CMD_ADD, 32'h0000_0100 + i);
    send_item(uvss_pkg::CMD_ADD, 32'h5555_AAAA);
    send_item(uvss_pkg::CMD_ADD, 32'h0000_0000);
    send_item(uvss_pkg::CMD_REMOVE, 32'h0000_010C);
    send_item(uvss_pkg::CMD_REMOVE, 32'h8000_0000);
    send_item(uvss_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
    send_item(uvss_pkg::CMD_LOOKUP, 32'hFFFF_FFFF);
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        no_gaps   = ($urandom_range(0, 2) == 0);
        pool_span = $urandom_range(4, POOL_SIZE);
      end
      if (n == RANDOM_ITEMS / 2) drain_results();
      send_item(pick_cmd(), pick_value());
      idle_gap();
    end

    drain_results();
    repeat (5) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/uvss_pkg.sv
rtl/uvss_cell.sv
rtl/unique_value_set_store_core.sv
tb/sv/unique_value_set_store_checker.sv
tb/sv/unique_value_set_store_core_tb.sv
